[sv/assert_macros.svh]
// Concurrent assertion helpers used by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising edge, quiet while reset is asserted.
`define OTB_ASSERT(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error(msg);

// Same check without a reset qualifier.
`define OTB_ASSERT_ALWAYS(label, clk, prop, msg) \
	label: assert property (@(posedge clk) prop) else $error(msg);

`endif

[sv/otb_pkg.sv]
package otb_pkg;

	localparam int TIME_W = 48;
	localparam int ID_W   = 32;
	localparam int DUR_W  = 32;
	localparam int SLOT_W = 3;
	localparam int MASK_W = 5;
	localparam int REP_W  = 3;

	// Expiries reported per tick at most.
	localparam int MAX_REPORTS = 5;

	typedef logic [TIME_W-1:0] time_t;
	typedef logic [ID_W-1:0]   id_t;

	localparam time_t TIME_MAX = '1;
	localparam id_t   ID_MAX   = '1;
	localparam id_t   ID_FIRST = ID_W'(1);

	localparam logic [1:0] ACT_TICK     = 2'd0;
	localparam logic [1:0] ACT_SCHEDULE = 2'd1;
	localparam logic [1:0] ACT_CANCEL   = 2'd2;

	localparam logic [1:0] KIND_SCHEDULE = 2'd0;
	localparam logic [1:0] KIND_CANCEL   = 2'd1;
	localparam logic [1:0] KIND_EXPIRY   = 2'd2;

endpackage

[sv/otb_rank.sv]
// Finds the slots due at time_next and orders them: earliest deadline first,
// ties to the lower slot. rank[i] is the number of due slots ahead of slot i.
module otb_rank import otb_pkg::*; #(
	parameter int SLOT_COUNT = 5,
	parameter int RANK_W     = 3
) (
	input  logic [SLOT_COUNT-1:0] armed,
	input  time_t                 deadline [SLOT_COUNT],
	input  time_t                 time_next,
	output logic [SLOT_COUNT-1:0] due,
	output logic [RANK_W-1:0]     rank [SLOT_COUNT],
	output logic [REP_W-1:0]      n_rep
);

	logic [SLOT_COUNT-1:0] ahead [SLOT_COUNT];
	logic [RANK_W-1:0]     due_cnt;

	always_comb begin
		for (int i = 0; i < SLOT_COUNT; i++) begin
			due[i] = armed[i] && (deadline[i] <= time_next);
		end
	end

	always_comb begin
		for (int i = 0; i < SLOT_COUNT; i++) begin
			for (int j = 0; j < SLOT_COUNT; j++) begin
				ahead[i][j] = (j != i) && due[j] &&
					((deadline[j] < deadline[i]) ||
					 ((deadline[j] == deadline[i]) && (j < i)));
			end
			rank[i] = RANK_W'($countones(ahead[i]));
		end
	end

	always_comb begin
		due_cnt = RANK_W'($countones(due));
		if (32'(due_cnt) > MAX_REPORTS) begin
			n_rep = REP_W'(MAX_REPORTS);
		end else begin
			n_rep = REP_W'(due_cnt);
		end
	end

endmodule

[sv/one_shot_timer_bank.sv]
// Bank of SLOT_COUNT one-shot timers on a microsecond count. Input words
// (tuser = action) are registered, then handled in one pass into the output
// register: a schedule or cancel is handled once that register is free, and
// one such word can be taken every cycle while m_tready is high. A tick first
// finds and orders the due slots (parallel deadline compares), then sends one
// expiry word per cycle while the output is not held, up to five, holding the
// input until the last; the single output register sets that pace. A tick
// with no expiry, or while disabled, gives no word. Writing enable from 0 to
// 1 disarms every slot; the id counter runs on. No clearing pass after reset.
`include "assert_macros.svh"

module one_shot_timer_bank import otb_pkg::*; #(
	parameter int SLOT_COUNT = 5
) (
	input  logic        clk,
	input  logic        arst_n,
	// input stream
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [39:0] s_tdata,   // slot[2:0], duration_us[34:3], zero pad
	input  logic [1:0]  s_tuser,   // action
	// result stream
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [47:0] m_tdata,   // slot_index[2:0], timer_id[34:3], wake_required[35],
	                               // active_mask[40:36], any_active[41], zero pad
	output logic [1:0]  m_tuser,   // kind
	output logic        m_tlast,
	// register port
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	localparam int RANK_W = $clog2(SLOT_COUNT + 1);

	// input stage
	logic              s1_valid_q;
	logic [1:0]        act_s1;
	logic [SLOT_W-1:0] slot_s1;
	logic [DUR_W-1:0]  dur_s1;

	// timer state
	time_t                 time_q;
	logic [SLOT_COUNT-1:0] armed_q;
	time_t                 dl_q [SLOT_COUNT];
	id_t                   tid_q [SLOT_COUNT];
	id_t                   next_id_q;
	logic                  enable_q;

	// tick sequencing
	logic                  emit_q;
	logic [REP_W-1:0]      k_q;
	logic [REP_W-1:0]      n_q;
	logic [SLOT_COUNT-1:0] due_q;
	logic [RANK_W-1:0]     rank_q [SLOT_COUNT];

	// output register
	logic              m_tvalid_q;
	logic [1:0]        kind_q;
	logic [SLOT_W-1:0] slot_out_q;
	id_t               id_out_q;
	logic              wake_q;
	logic [MASK_W-1:0] mask_q;
	logic              any_q;
	logic              last_q;

	// combinational
	time_t                 time_next;
	logic [SLOT_COUNT-1:0] due;
	logic [RANK_W-1:0]     rank [SLOT_COUNT];
	logic [REP_W-1:0]      n_rep;
	logic [SLOT_COUNT-1:0] slot_hit;
	logic                  slot_ok;
	logic [TIME_W:0]       dl_sum;
	time_t                 dl_new;
	logic                  wake;
	logic                  sch_take;
	logic [SLOT_COUNT-1:0] emit_sel;
	logic [SLOT_W-1:0]     emit_slot;
	id_t                   emit_id;
	logic                  emit_last;
	logic                  out_ready;
	logic                  sched_go;
	logic                  cancel_go;
	logic                  rank_go;
	logic                  emit_go;
	logic                  release_s1;
	logic [SLOT_COUNT-1:0] armed_d;
	logic [MASK_W-1:0]     mask_d;
	logic                  cfg_we;
	logic                  clear_slots;

	assign pready      = 1'b1;
	assign cfg_we      = psel && penable && pwrite && pready && !paddr[2];
	assign clear_slots = cfg_we && pwdata[0] && !enable_q;
	assign prdata      = paddr[2] ? 32'd0 : {31'd0, enable_q};

	assign time_next = time_q + TIME_W'(1);

	otb_rank #(
		.SLOT_COUNT(SLOT_COUNT),
		.RANK_W    (RANK_W)
	) u_rank (
		.armed    (armed_q),
		.deadline (dl_q),
		.time_next(time_next),
		.due      (due),
		.rank     (rank),
		.n_rep    (n_rep)
	);

	// schedule path
	always_comb begin
		for (int i = 0; i < SLOT_COUNT; i++) begin
			slot_hit[i] = (32'(slot_s1) == 32'(i));
		end
		slot_ok  = 32'(slot_s1) < SLOT_COUNT;
		sch_take = enable_q && slot_ok;
		dl_sum   = {1'b0, time_q} + (TIME_W + 1)'(dur_s1);
		dl_new   = dl_sum[TIME_W] ? TIME_MAX : dl_sum[TIME_W-1:0];
		// wake only when earlier than every armed deadline
		wake = 1'b1;
		for (int i = 0; i < SLOT_COUNT; i++) begin
			if (armed_q[i] && !(dl_new < dl_q[i])) begin
				wake = 1'b0;
			end
		end
	end

	// expiry select: the due slot whose rank matches the report count
	always_comb begin
		emit_slot = '0;
		emit_id   = '0;
		for (int i = 0; i < SLOT_COUNT; i++) begin
			emit_sel[i] = due_q[i] && (32'(rank_q[i]) == 32'(k_q));
			if (emit_sel[i]) begin
				emit_slot = emit_slot | SLOT_W'(i);
				emit_id   = emit_id | tid_q[i];
			end
		end
		emit_last = (k_q == REP_W'(n_q - REP_W'(1)));
	end

	// control
	always_comb begin
		out_ready  = !m_tvalid_q || m_tready;
		sched_go   = 1'b0;
		cancel_go  = 1'b0;
		rank_go    = 1'b0;
		emit_go    = 1'b0;
		release_s1 = 1'b0;
		case (act_s1)
			ACT_SCHEDULE: begin
				sched_go   = s1_valid_q && out_ready;
				release_s1 = sched_go;
			end
			ACT_CANCEL: begin
				cancel_go  = s1_valid_q && out_ready;
				release_s1 = cancel_go;
			end
			ACT_TICK: begin
				if (!emit_q) begin
					rank_go    = s1_valid_q;
					release_s1 = rank_go && (!enable_q || (n_rep == '0));
				end else begin
					emit_go    = s1_valid_q && out_ready;
					release_s1 = emit_go && emit_last;
				end
			end
			default: begin
				release_s1 = s1_valid_q;
			end
		endcase
		s_tready = !s1_valid_q || release_s1;
	end

	always_comb begin
		armed_d = armed_q;
		if (sched_go && sch_take) begin
			armed_d = armed_q | slot_hit;
		end else if (cancel_go && sch_take) begin
			armed_d = armed_q & ~slot_hit;
		end else if (emit_go) begin
			armed_d = armed_q & ~emit_sel;
		end
		mask_d = '0;
		for (int b = 0; b < MASK_W; b++) begin
			if (b < SLOT_COUNT) begin
				mask_d[b] = armed_d[b];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (s_tready) begin
			s1_valid_q <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			act_s1  <= s_tuser;
			slot_s1 <= s_tdata[2:0];
			dur_s1  <= s_tdata[34:3];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enable_q  <= 1'b0;
			time_q    <= '0;
			armed_q   <= '0;
			next_id_q <= ID_FIRST;
			emit_q    <= 1'b0;
			k_q       <= '0;
			n_q       <= '0;
		end else begin
			if (cfg_we) begin
				enable_q <= pwdata[0];
			end
			if (clear_slots) begin
				armed_q <= '0;
			end else begin
				armed_q <= armed_d;
			end
			if (sched_go && sch_take) begin
				next_id_q <= (next_id_q == ID_MAX) ? ID_FIRST : next_id_q + ID_W'(1);
			end
			if (rank_go) begin
				time_q <= time_next;
				emit_q <= enable_q && (n_rep != '0);
				k_q    <= '0;
				n_q    <= n_rep;
			end else if (emit_go) begin
				k_q <= k_q + REP_W'(1);
				if (emit_last) begin
					emit_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rank_go) begin
			due_q  <= due;
			rank_q <= rank;
		end
		for (int i = 0; i < SLOT_COUNT; i++) begin
			if (sched_go && sch_take && slot_hit[i]) begin
				dl_q[i]  <= dl_new;
				tid_q[i] <= next_id_q;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (out_ready) begin
			m_tvalid_q <= sched_go || cancel_go || emit_go;
		end
	end

	always_ff @(posedge clk) begin
		if (sched_go || cancel_go || emit_go) begin
			mask_q <= mask_d;
			any_q  <= |armed_d;
			if (emit_go) begin
				kind_q     <= KIND_EXPIRY;
				slot_out_q <= emit_slot;
				id_out_q   <= emit_id;
				wake_q     <= 1'b0;
				last_q     <= emit_last;
			end else if (sched_go) begin
				kind_q     <= KIND_SCHEDULE;
				slot_out_q <= slot_s1;
				id_out_q   <= sch_take ? next_id_q : '0;
				wake_q     <= sch_take && wake;
				last_q     <= 1'b1;
			end else begin
				kind_q     <= KIND_CANCEL;
				slot_out_q <= slot_s1;
				id_out_q   <= '0;
				wake_q     <= 1'b0;
				last_q     <= 1'b1;
			end
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tuser  = kind_q;
	assign m_tlast  = last_q;
	assign m_tdata  = {6'd0, any_q, mask_q, wake_q, id_out_q, slot_out_q};

	`OTB_ASSERT(a_emit_onehot, clk, arst_n, emit_go |-> $onehot(emit_sel), "expiry select not one-hot")
	`OTB_ASSERT(a_id_nonzero, clk, arst_n, next_id_q != '0, "next timer id is zero")
	`OTB_ASSERT(a_emit_in_tick, clk, arst_n, emit_q |-> (s1_valid_q && (act_s1 == ACT_TICK)), "expiry phase without a tick")
	`OTB_ASSERT(a_k_bound, clk, arst_n, emit_q |-> (k_q < n_q), "report count past limit")
	`OTB_ASSERT(a_expired_disarmed, clk, arst_n, emit_go |=> ((armed_q & $past(emit_sel)) == '0), "expired slot still armed")

endmodule

[bench/one_shot_timer_bank_test.sv]
`timescale 1ns / 1ps

module one_shot_timer_bank_test import otb_pkg::*; ();

	localparam int SLOTS = 5;
	localparam int CYCLE_LIMIT = 500000;
	localparam int SETTLE_CYCLES = 16;
	localparam int RANDOM_WORDS = 240;
	localparam logic [2:0] REG_ENABLE = 3'd0;
	localparam logic [1:0] ACT_UNKNOWN = 2'd3;

	typedef struct packed {
		logic [1:0]       action;
		logic [2:0]       slot;
		logic [DUR_W-1:0] dur;
	} cmd_t;

	typedef struct packed {
		logic [1:0]        kind;
		logic [2:0]        slot;
		id_t               id;
		logic              wake;
		logic [MASK_W-1:0] mask;
		logic              any;
		logic              last;
	} reply_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [39:0] s_tdata;   // slot[2:0], duration_us[34:3], zero pad
	logic [1:0]  s_tuser;   // action
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [47:0] m_tdata;   // slot_index[2:0], timer_id[34:3], wake_required[35],
	                        // active_mask[40:36], any_active[41], zero pad
	logic [1:0]  m_tuser;   // kind
	logic        m_tlast;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [2:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;

	one_shot_timer_bank #(.SLOT_COUNT(SLOTS)) dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser),
		.m_tlast(m_tlast),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	always #5 clk = ~clk;

	// timer bank as the bench sees it
	time_t            now_us = '0;
	logic [SLOTS-1:0] armed = '0;
	time_t            deadline [SLOTS];
	id_t              owner_id [SLOTS];
	id_t              next_id = ID_FIRST;
	logic             running = 1'b0;

	cmd_t   pending_words[$];
	reply_t replies_due[$];
	cmd_t   drive_word = '0;
	reply_t want;
	logic   in_fire = 1'b0;
	logic   quiet = 1'b0;
	logic   burst_mode = 1'b0;
	int     send_gap = 0;
	int     hold_ready = 0;
	int     cycles = 0;
	int     errors = 0;

	assign s_tdata = {5'b0, drive_word.dur, drive_word.slot};
	assign s_tuser = drive_word.action;

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 96)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	task automatic push_reply(input logic [1:0] kind, input logic [2:0] slot, input id_t id,
			input logic wake, input logic last);
		reply_t r;
		r = '{kind, slot, id, wake, armed, |armed, last};
		replies_due = {replies_due, r};
	endtask

	task automatic apply_cmd(input cmd_t c);
		logic [TIME_W:0]  sum;
		logic [TIME_W:0]  earliest;
		time_t            dl;
		logic             wake;
		logic [SLOTS-1:0] due;
		int               order[$];
		int               best;
		case (c.action)
			ACT_SCHEDULE: begin
				if (!running || 32'(c.slot) >= SLOTS) begin
					push_reply(KIND_SCHEDULE, c.slot, '0, 1'b0, 1'b1);
				end else begin
					sum = {1'b0, now_us} + (TIME_W + 1)'(c.dur);
					dl = sum[TIME_W] ? TIME_MAX : sum[TIME_W-1:0];
					earliest = {1'b1, {TIME_W{1'b0}}};
					for (int i = 0; i < SLOTS; i++)
						if (armed[i] && {1'b0, deadline[i]} < earliest)
							earliest = {1'b0, deadline[i]};
					wake = {1'b0, dl} < earliest;
					armed[c.slot] = 1'b1;
					deadline[c.slot] = dl;
					owner_id[c.slot] = next_id;
					push_reply(KIND_SCHEDULE, c.slot, next_id, wake, 1'b1);
					next_id = (next_id == ID_MAX) ? ID_FIRST : next_id + ID_W'(1);
				end
			end
			ACT_CANCEL: begin
				if (running && 32'(c.slot) < SLOTS)
					armed[c.slot] = 1'b0;
				push_reply(KIND_CANCEL, c.slot, '0, 1'b0, 1'b1);
			end
			ACT_TICK: begin
				now_us = now_us + TIME_W'(1);
				if (running) begin
					for (int i = 0; i < SLOTS; i++)
						due[i] = armed[i] && deadline[i] <= now_us;
					// earliest deadline first, ties to the lower slot
					while (due != '0 && order.size() < MAX_REPORTS) begin
						best = -1;
						for (int i = 0; i < SLOTS; i++)
							if (due[i] && (best < 0 || deadline[i] < deadline[best]))
								best = i;
						order = {order, best};
						due[best] = 1'b0;
					end
					foreach (order[k]) begin
						armed[order[k]] = 1'b0;
						push_reply(KIND_EXPIRY, 3'(order[k]), owner_id[order[k]], 1'b0,
							k == order.size() - 1);
					end
				end
			end
			default: ;
		endcase
	endtask

	task automatic check_field(input string name, input logic [31:0] exp_v,
			input logic [31:0] got_v);
		if (exp_v !== got_v) begin
			$display("%0t: %s expected %0h, got %0h", $time, name, exp_v, got_v);
			errors++;
		end
	endtask

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles % 128 == 0)
			burst_mode <= ($urandom_range(0, 3) == 0);
		if (cycles == CYCLE_LIMIT) begin
			$display("RESULT: ERROR");
			$finish;
		end
	end

	// output check first, then prediction of the word taken at this edge
	always @(posedge clk) begin
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				if (replies_due.size() == 0) begin
					$display("%0t: unexpected word, got kind %0h tdata %0h last %0b",
						$time, m_tuser, m_tdata, m_tlast);
					errors++;
				end else begin
					want = replies_due[0];
					replies_due.delete(0);
					check_field("kind", 32'(want.kind), 32'(m_tuser));
					check_field("slot_index", 32'(want.slot), 32'(m_tdata[2:0]));
					check_field("timer_id", want.id, m_tdata[34:3]);
					check_field("wake_required", 32'(want.wake), 32'(m_tdata[35]));
					check_field("active_mask", 32'(want.mask), 32'(m_tdata[40:36]));
					check_field("any_active", 32'(want.any), 32'(m_tdata[41]));
					check_field("last", 32'(want.last), 32'(m_tlast));
				end
			end
			if (s_tvalid && s_tready)
				apply_cmd(drive_word);
		end
		in_fire <= s_tvalid && s_tready;
		quiet <= pending_words.size() == 0 && !(s_tvalid && !(s_tvalid && s_tready))
			&& !s_tvalid && replies_due.size() == 0;
	end

	always @(negedge clk) begin
		if (!arst_n || (s_tvalid && !in_fire)) begin
			// hold the current word
		end else if (send_gap > 0) begin
			send_gap <= send_gap - 1;
			s_tvalid <= 1'b0;
		end else if (pending_words.size() != 0) begin
			drive_word <= pending_words[0];
			pending_words.delete(0);
			s_tvalid <= 1'b1;
			send_gap <= burst_mode ? 0 : pick_gap();
		end else begin
			s_tvalid <= 1'b0;
		end
	end

	always @(negedge clk) begin
		if (hold_ready > 0) begin
			hold_ready <= hold_ready - 1;
			m_tready <= 1'b0;
		end else begin
			m_tready <= 1'b1;
			if (!burst_mode && $urandom_range(0, 3) == 0)
				hold_ready <= pick_gap();
		end
	end

	task automatic queue_cmd(input logic [1:0] action, input logic [2:0] slot,
			input logic [DUR_W-1:0] dur);
		cmd_t c;
		c = '{action, slot, dur};
		pending_words = {pending_words, c};
	endtask

	task automatic wait_idle();
		do
			@(negedge clk);
		while (!quiet);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic set_enable(input logic en);
		logic [31:0] readback;
		@(negedge clk);
		psel = 1'b1;
		pwrite = 1'b1;
		penable = 1'b0;
		paddr = REG_ENABLE;
		pwdata = {31'b0, en};
		@(negedge clk);
		penable = 1'b1;
		do
			@(posedge clk);
		while (!pready);
		// rising enable wipes every slot, the id counter runs on
		if (en && !running) begin
			armed = '0;
			for (int i = 0; i < SLOTS; i++) begin
				deadline[i] = '0;
				owner_id[i] = '0;
			end
		end
		running = en;
		@(negedge clk);
		pwrite = 1'b0;
		penable = 1'b0;
		@(negedge clk);
		penable = 1'b1;
		do
			@(posedge clk);
		while (!pready);
		readback = prdata;
		@(negedge clk);
		psel = 1'b0;
		penable = 1'b0;
		check_field("enable readback", {31'b0, running}, readback);
	endtask

	function automatic cmd_t random_cmd();
		cmd_t c;
		int   r;
		r = $urandom_range(0, 99);
		c.action = r < 45 ? ACT_TICK : r < 78 ? ACT_SCHEDULE : r < 95 ? ACT_CANCEL : ACT_UNKNOWN;
		c.slot = 3'($urandom_range(0, 9) < 8 ? $urandom_range(0, SLOTS - 1)
			: $urandom_range(SLOTS, 7));
		r = $urandom_range(0, 99);
		c.dur = r < 65 ? $urandom_range(0, 6) : r < 90 ? $urandom_range(0, 40) : $urandom();
		return c;
	endfunction

	initial begin
		int   sent;
		int   n;
		cmd_t c;
		for (int i = 0; i < SLOTS; i++) begin
			deadline[i] = '0;
			owner_id[i] = '0;
		end
		repeat (10) @(negedge clk);
		arst_n = 1'b1;

		set_enable(1'b1);
		// zero delay on an empty bank, then it fires on the next tick
		queue_cmd(ACT_SCHEDULE, 3'd0, '0);
		queue_cmd(ACT_TICK, 3'd0, '0);
		queue_cmd(ACT_SCHEDULE, 3'd4, '1);
		queue_cmd(ACT_SCHEDULE, 3'd1, 32'd3);
		queue_cmd(ACT_SCHEDULE, 3'd2, 32'd3);
		queue_cmd(ACT_SCHEDULE, 3'd3, 32'd5);
		queue_cmd(ACT_SCHEDULE, 3'd0, 32'd1);
		queue_cmd(ACT_SCHEDULE, 3'd0, 32'd2);
		// slots past the bank
		queue_cmd(ACT_SCHEDULE, 3'd5, 32'd7);
		queue_cmd(ACT_SCHEDULE, 3'd7, '0);
		queue_cmd(ACT_CANCEL, 3'd3, '0);
		queue_cmd(ACT_CANCEL, 3'd6, '1);
		queue_cmd(ACT_UNKNOWN, 3'd7, '1);
		queue_cmd(ACT_TICK, 3'd7, '1);
		queue_cmd(ACT_TICK, 3'd0, '0);
		queue_cmd(ACT_TICK, 3'd0, '0);
		// all five due on one tick, mixed deadlines
		queue_cmd(ACT_SCHEDULE, 3'd4, 32'd1);
		queue_cmd(ACT_SCHEDULE, 3'd3, 32'd0);
		queue_cmd(ACT_SCHEDULE, 3'd2, 32'd1);
		queue_cmd(ACT_SCHEDULE, 3'd1, 32'd0);
		queue_cmd(ACT_SCHEDULE, 3'd0, 32'd1);
		queue_cmd(ACT_TICK, 3'd0, '0);
		queue_cmd(ACT_SCHEDULE, 3'd2, 32'd0);
		wait_idle();

		// disabled: refused schedule, inert cancel, armed slot waits
		set_enable(1'b0);
		queue_cmd(ACT_SCHEDULE, 3'd1, '0);
		queue_cmd(ACT_CANCEL, 3'd2, '0);
		queue_cmd(ACT_TICK, 3'd0, '0);
		queue_cmd(ACT_TICK, 3'd0, '0);
		wait_idle();
		set_enable(1'b1);
		queue_cmd(ACT_TICK, 3'd0, '0);
		queue_cmd(ACT_SCHEDULE, 3'd0, 32'd1);
		wait_idle();
		// writing 1 over 1 keeps the armed slot
		set_enable(1'b1);
		queue_cmd(ACT_TICK, 3'd0, '0);
		queue_cmd(ACT_TICK, 3'd0, '0);
		wait_idle();

		sent = 0;
		while (sent < RANDOM_WORDS) begin
			set_enable($urandom_range(0, 4) != 0);
			n = 0;
			while (n < 50 && sent < RANDOM_WORDS) begin
				c = random_cmd();
				pending_words = {pending_words, c};
				if (c.action != ACT_UNKNOWN) begin
					sent++;
					n++;
				end
			end
			wait_idle();
		end

		if (replies_due.size() != 0) begin
			$display("%0t: %0d expected words never arrived", $time, replies_due.size());
			errors += replies_due.size();
		end
		if (errors == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
